// ----- rtl/core/lfrs_pkg.sv -----
// ----------------------------------------------------------------------------
// lfrs_pkg
// Shared field widths and control bundles of the lowest free room scheduler.
// ----------------------------------------------------------------------------
package lfrs_pkg;

	// fixed widths of the transaction fields
	localparam int START_BITS     = 20;
	localparam int CFG_BITS       = 8;
	localparam int ROOM_OUT_BITS  = 7;
	localparam int TIME_OUT_BITS  = 40;
	localparam int COUNT_OUT_BITS = 17;

	// room store access controls
	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic clear;
	} store_ctl_t;

	// scan sample controls
	typedef struct packed {
		logic sample;
		logic first;
	} scan_ctl_t;

endpackage

// ----- rtl/core/lowest_free_room_scheduler_top.sv -----
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler_top
// Assigns each job to the lowest free room or the earliest freeing room and
// tracks the busiest room.
// ----------------------------------------------------------------------------
// Each job is accepted in the idle state, reads the free time of each room
// (room_count rooms, taken as 1 when zero and as MAX_ROOMS when larger) through
// the single read port of the room store, finishes the scan, reads the chosen
// room's use count and then writes the room back and loads the result. A job is
// accepted while the previous result still waits in the output register. Reset
// and a job flagged first_job leave every room free and unused at once, with no
// clearing pass. Jobs must arrive in rising start order; the user must write the
// room count register only while the block is idle; the block does not enforce this.
module lowest_free_room_scheduler_top #(
	parameter int MAX_ROOMS  = 128,
	parameter int TIME_BITS  = 40,
	parameter int COUNT_BITS = 17
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lfrs_pkg::CFG_BITS-1:0]          cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [lfrs_pkg::START_BITS-1:0]        req_start,
	input  logic [lfrs_pkg::START_BITS-1:0]        req_end,
	input  logic                                   first_job,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [lfrs_pkg::ROOM_OUT_BITS-1:0]     room,
	output logic [lfrs_pkg::TIME_OUT_BITS-1:0]     actual_start,
	output logic [lfrs_pkg::TIME_OUT_BITS-1:0]     actual_end,
	output logic [lfrs_pkg::ROOM_OUT_BITS-1:0]     busiest_room,
	output logic [lfrs_pkg::COUNT_OUT_BITS-1:0]    busiest_count
);

	localparam int RIDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
	localparam int RCNT_W = $clog2(MAX_ROOMS + 1);
	localparam int CW     = (lfrs_pkg::CFG_BITS > RCNT_W) ? lfrs_pkg::CFG_BITS : RCNT_W;
	localparam int SW     = lfrs_pkg::START_BITS;
	localparam int ROW    = lfrs_pkg::ROOM_OUT_BITS;
	localparam int OTW    = lfrs_pkg::TIME_OUT_BITS;
	localparam int OCW    = lfrs_pkg::COUNT_OUT_BITS;
	localparam int TW1    = TIME_BITS + 1;
	localparam logic [CW-1:0] MAX_EXT = CW'(MAX_ROOMS);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_FLUSH  = 3'd2;
	localparam logic [2:0] ST_PICK   = 3'd3;
	localparam logic [2:0] ST_UPDATE = 3'd4;

	logic [2:0]                   state_q;
	logic [lfrs_pkg::CFG_BITS-1:0] room_count_q;
	logic [SW-1:0]                start_q;
	logic [SW-1:0]                dur_q;
	logic [RIDX_W-1:0]            last_q;
	logic [RIDX_W-1:0]            addr_q;
	logic                         rd_pend_s1;
	logic                         rd_first_s1;
	logic [RIDX_W-1:0]            rd_idx_s1;
	logic [RIDX_W-1:0]            best_room_q;
	logic [COUNT_BITS-1:0]        best_count_q;
	logic                         out_valid_q;
	logic [RIDX_W-1:0]            out_room_q;
	logic [TIME_BITS-1:0]         out_start_q;
	logic [TIME_BITS-1:0]         out_end_q;
	logic [RIDX_W-1:0]            out_best_room_q;
	logic [COUNT_BITS-1:0]        out_best_count_q;

	logic                         in_fire;
	logic                         commit;
	logic [CW-1:0]                rc_ext;
	logic [CW-1:0]                rc_lim;
	logic [RIDX_W-1:0]            last_idx;
	lfrs_pkg::store_ctl_t         st_ctl;
	lfrs_pkg::scan_ctl_t          sc_ctl;
	logic [RIDX_W-1:0]            rd_addr;
	logic [TIME_BITS-1:0]         rd_time;
	logic [COUNT_BITS-1:0]        rd_count;
	logic [TIME_BITS-1:0]         start_ext;
	logic [RIDX_W-1:0]            pick_idx;
	logic [TIME_BITS-1:0]         pick_begin;
	logic [TW1-1:0]               end_sum;
	logic [TIME_BITS-1:0]         finish;
	logic [COUNT_BITS-1:0]        new_count;
	logic                         best_take;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign commit    = (state_q == ST_UPDATE) && (!out_valid_q || out_ready);
	assign start_ext = TIME_BITS'(start_q);

	// room count clamped to one .. MAX_ROOMS
	always_comb begin
		rc_ext = CW'(room_count_q);
		rc_lim = rc_ext;
		if (rc_ext == '0) begin
			rc_lim = CW'(1);
		end else if (rc_ext > MAX_EXT) begin
			rc_lim = MAX_EXT;
		end
		last_idx = RIDX_W'(rc_lim - CW'(1));
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			room_count_q <= lfrs_pkg::CFG_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			room_count_q <= cfg_data;
		end
	end

	// job registers taken at accept
	always_ff @(posedge clk) begin
		if (in_fire) begin
			start_q <= req_start;
			dur_q   <= (req_end > req_start) ? (req_end - req_start) : '0;
			last_q  <= last_idx;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			addr_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_SCAN;
						addr_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (addr_q == last_q) begin
						state_q <= ST_FLUSH;
					end else begin
						addr_q <= addr_q + RIDX_W'(1);
					end
				end
				ST_FLUSH: state_q <= ST_PICK;
				ST_PICK:  state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (commit) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// read pipeline tags follow the store's registered read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1  <= 1'b0;
			rd_first_s1 <= 1'b0;
			rd_idx_s1   <= '0;
		end else begin
			rd_pend_s1  <= (state_q == ST_SCAN);
			rd_first_s1 <= (addr_q == '0);
			rd_idx_s1   <= addr_q;
		end
	end

	// store access: scan reads, then the chosen room is read and written back
	always_comb begin
		st_ctl.rd_en = (state_q == ST_SCAN) || (state_q == ST_PICK);
		st_ctl.wr_en = commit;
		st_ctl.clear = in_fire && first_job;
		rd_addr      = (state_q == ST_PICK) ? pick_idx : addr_q;
		sc_ctl.sample = rd_pend_s1;
		sc_ctl.first  = rd_first_s1;
	end

	lfrs_room_store #(
		.MAX_ROOMS  (MAX_ROOMS),
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS),
		.RIDX_W     (RIDX_W)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (st_ctl),
		.rd_addr  (rd_addr),
		.wr_addr  (pick_idx),
		.wr_time  (finish),
		.wr_count (new_count),
		.rd_time  (rd_time),
		.rd_count (rd_count)
	);

	lfrs_scan #(
		.TIME_BITS (TIME_BITS),
		.RIDX_W    (RIDX_W)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (sc_ctl),
		.idx        (rd_idx_s1),
		.ftime      (rd_time),
		.start      (start_ext),
		.pick_idx   (pick_idx),
		.pick_begin (pick_begin)
	);

	// saturating end time, saturating use count, busiest room compare
	always_comb begin
		end_sum   = {1'b0, pick_begin} + TW1'(dur_q);
		finish    = end_sum[TIME_BITS] ? '1 : end_sum[TIME_BITS-1:0];
		new_count = (rd_count == '1) ? rd_count : (rd_count + COUNT_BITS'(1));
		best_take = (new_count > best_count_q) ||
			((new_count == best_count_q) && (pick_idx < best_room_q));
	end

	// busiest room tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_room_q  <= '0;
			best_count_q <= '0;
		end else if (in_fire && first_job) begin
			best_room_q  <= '0;
			best_count_q <= '0;
		end else if (commit && best_take) begin
			best_room_q  <= pick_idx;
			best_count_q <= new_count;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			out_room_q       <= pick_idx;
			out_start_q      <= pick_begin;
			out_end_q        <= finish;
			out_best_room_q  <= best_take ? pick_idx : best_room_q;
			out_best_count_q <= best_take ? new_count : best_count_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign room          = ROW'(out_room_q);
	assign actual_start  = OTW'(out_start_q);
	assign actual_end    = OTW'(out_end_q);
	assign busiest_room  = ROW'(out_best_room_q);
	assign busiest_count = OCW'(out_best_count_q);

	// chosen room lies within the rooms in use
	a_pick_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) |-> (pick_idx <= last_q))
		else $error("chosen room beyond room count");

	// busiest count only falls when a first job clears the state
	a_best_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_fire && first_job) |=> (best_count_q >= $past(best_count_q)))
		else $error("busiest count decreased without a clear");

	// a held result never ends before it begins
	a_end_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_end_q >= out_start_q))
		else $error("result ends before it starts");

endmodule

// ----- rtl/core/lfrs_room_store.sv -----
// ----------------------------------------------------------------------------
// lfrs_room_store
// Per-room free time and use count memories with one registered read port,
// one write port and per-room valid bits that make cleared rooms read zero.
// ----------------------------------------------------------------------------
module lfrs_room_store #(
	parameter int MAX_ROOMS  = 128,
	parameter int TIME_BITS  = 40,
	parameter int COUNT_BITS = 17,
	parameter int RIDX_W     = 7
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  lfrs_pkg::store_ctl_t      ctl,
	input  logic [RIDX_W-1:0]         rd_addr,
	input  logic [RIDX_W-1:0]         wr_addr,
	input  logic [TIME_BITS-1:0]      wr_time,
	input  logic [COUNT_BITS-1:0]     wr_count,
	output logic [TIME_BITS-1:0]      rd_time,
	output logic [COUNT_BITS-1:0]     rd_count
);

	logic [TIME_BITS-1:0]  time_mem [MAX_ROOMS];
	logic [COUNT_BITS-1:0] count_mem [MAX_ROOMS];
	logic [MAX_ROOMS-1:0]  valid_q;
	logic [TIME_BITS-1:0]  rd_time_s1;
	logic [COUNT_BITS-1:0] rd_count_s1;
	logic                  rd_valid_s1;

	// memory write and registered read
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			time_mem[wr_addr]  <= wr_time;
			count_mem[wr_addr] <= wr_count;
		end
		if (ctl.rd_en) begin
			rd_time_s1  <= time_mem[rd_addr];
			rd_count_s1 <= count_mem[rd_addr];
		end
	end

	// valid bits: a room not written since the last clear reads as free and unused
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (ctl.clear) begin
				valid_q <= '0;
			end else if (ctl.wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (ctl.rd_en) begin
				rd_valid_s1 <= valid_q[rd_addr];
			end
		end
	end

	assign rd_time  = rd_valid_s1 ? rd_time_s1 : '0;
	assign rd_count = rd_valid_s1 ? rd_count_s1 : '0;

endmodule

// ----- rtl/core/lfrs_scan.sv -----
// ----------------------------------------------------------------------------
// lfrs_scan
// Walks the room free times one per cycle, tracking the lowest free room and
// the earliest freeing room, and presents the chosen room and its begin time.
// ----------------------------------------------------------------------------
module lfrs_scan #(
	parameter int TIME_BITS = 40,
	parameter int RIDX_W    = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lfrs_pkg::scan_ctl_t   ctl,
	input  logic [RIDX_W-1:0]     idx,
	input  logic [TIME_BITS-1:0]  ftime,
	input  logic [TIME_BITS-1:0]  start,
	output logic [RIDX_W-1:0]     pick_idx,
	output logic [TIME_BITS-1:0]  pick_begin
);

	logic                 found_q;
	logic [RIDX_W-1:0]    free_idx_q;
	logic [RIDX_W-1:0]    min_idx_q;
	logic [TIME_BITS-1:0] min_time_q;
	logic                 is_free;

	assign is_free = (ftime <= start);

	// found flag restarts with the first room of each scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (ctl.sample) begin
			if (ctl.first) begin
				found_q <= is_free;
			end else if (is_free) begin
				found_q <= 1'b1;
			end
		end
	end

	// lowest free room and earliest freeing room, lower number kept on ties
	always_ff @(posedge clk) begin
		if (ctl.sample) begin
			if ((ctl.first || !found_q) && is_free) begin
				free_idx_q <= idx;
			end
			if (ctl.first || (ftime < min_time_q)) begin
				min_idx_q  <= idx;
				min_time_q <= ftime;
			end
		end
	end

	assign pick_idx   = found_q ? free_idx_q : min_idx_q;
	assign pick_begin = found_q ? start : min_time_q;

endmodule

// ----- verif/lowest_free_room_scheduler_checker.sv -----
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler_checker
// Watches the configuration, job and result channels of the scheduler, keeps
// its own copy of the room table, predicts every booking and compares each
// result transaction field by field with the oldest pending prediction.
// ----------------------------------------------------------------------------
module lowest_free_room_scheduler_checker #(
	parameter int MAX_ROOMS  = 128,
	parameter int TIME_BITS  = 40,
	parameter int COUNT_BITS = 17
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic                                cfg_ready,
	input  logic [lfrs_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic [lfrs_pkg::START_BITS-1:0]     req_start,
	input  logic [lfrs_pkg::START_BITS-1:0]     req_end,
	input  logic                                first_job,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic [lfrs_pkg::ROOM_OUT_BITS-1:0]  room,
	input  logic [lfrs_pkg::TIME_OUT_BITS-1:0]  actual_start,
	input  logic [lfrs_pkg::TIME_OUT_BITS-1:0]  actual_end,
	input  logic [lfrs_pkg::ROOM_OUT_BITS-1:0]  busiest_room,
	input  logic [lfrs_pkg::COUNT_OUT_BITS-1:0] busiest_count,
	output int                                  mismatches,
	output int                                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [63:0] TIME_TOP  = (TIME_BITS >= 64) ? '1 : ((64'd1 << TIME_BITS) - 64'd1);
	localparam logic [63:0] COUNT_TOP = (COUNT_BITS >= 32) ? 64'hFFFF_FFFF :
		((64'd1 << COUNT_BITS) - 64'd1);

	// one predicted booking
	typedef struct packed {
		logic [lfrs_pkg::ROOM_OUT_BITS-1:0]  room;
		logic [lfrs_pkg::TIME_OUT_BITS-1:0]  t_start;
		logic [lfrs_pkg::TIME_OUT_BITS-1:0]  t_end;
		logic [lfrs_pkg::ROOM_OUT_BITS-1:0]  top_room;
		logic [lfrs_pkg::COUNT_OUT_BITS-1:0] top_count;
	} booking_t;

	booking_t       booking_q[$];
	logic [7:0]     rooms_cfg;
	logic [63:0]    free_at [MAX_ROOMS];
	logic [63:0]    uses [MAX_ROOMS];
	int             lead_room;
	logic [63:0]    lead_count;

	// wipe the room table
	task automatic clear_rooms();
		for (int i = 0; i < MAX_ROOMS; i++) begin
			free_at[i] = '0;
			uses[i] = '0;
		end
		lead_room = 0;
		lead_count = '0;
	endtask

	// book one job into the room table and queue the expected result
	task automatic book_job(input logic [lfrs_pkg::START_BITS-1:0] s,
			input logic [lfrs_pkg::START_BITS-1:0] e, input logic clr);
		logic [63:0] dur;
		logic [63:0] t0;
		logic [63:0] t1;
		int          rooms;
		int          pick;
		bit          found;
		booking_t    bk;
		dur = (e > s) ? 64'(e - s) : 64'd0;
		if (clr)
			clear_rooms();
		rooms = int'(rooms_cfg);
		if (rooms < 1)
			rooms = 1;
		if (rooms > MAX_ROOMS)
			rooms = MAX_ROOMS;
		// lowest room already free
		found = 1'b0;
		pick = 0;
		for (int i = 0; i < rooms; i++) begin
			if (!found && free_at[i] <= 64'(s)) begin
				pick = i;
				found = 1'b1;
			end
		end
		// otherwise the earliest freeing room, lower number on ties
		if (found) begin
			t0 = 64'(s);
		end else begin
			pick = 0;
			for (int i = 1; i < rooms; i++)
				if (free_at[i] < free_at[pick])
					pick = i;
			t0 = free_at[pick];
		end
		t1 = (dur > TIME_TOP - t0) ? TIME_TOP : t0 + dur;
		free_at[pick] = t1;
		if (uses[pick] < COUNT_TOP)
			uses[pick] = uses[pick] + 64'd1;
		if (uses[pick] > lead_count || (uses[pick] == lead_count && pick < lead_room)) begin
			lead_room = pick;
			lead_count = uses[pick];
		end
		bk.room = pick[lfrs_pkg::ROOM_OUT_BITS-1:0];
		bk.t_start = t0[lfrs_pkg::TIME_OUT_BITS-1:0];
		bk.t_end = t1[lfrs_pkg::TIME_OUT_BITS-1:0];
		bk.top_room = lead_room[lfrs_pkg::ROOM_OUT_BITS-1:0];
		bk.top_count = lead_count[lfrs_pkg::COUNT_OUT_BITS-1:0];
		booking_q.push_back(bk);
	endtask

	// print one mismatch line and count it
	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		mismatches++;
		$display("mismatch on %s: got %0h, expected %0h at %0t", field, got, want, $time);
	endtask

	// compare one result transaction with the oldest booking
	task automatic check_result();
		booking_t bk;
		if (booking_q.size() == 0) begin
			report_mismatch("unexpected result", 64'(room), 64'd0);
		end else begin
			bk = booking_q.pop_front();
			if (room !== bk.room)
				report_mismatch("room", 64'(room), 64'(bk.room));
			if (actual_start !== bk.t_start)
				report_mismatch("actual_start", 64'(actual_start), 64'(bk.t_start));
			if (actual_end !== bk.t_end)
				report_mismatch("actual_end", 64'(actual_end), 64'(bk.t_end));
			if (busiest_room !== bk.top_room)
				report_mismatch("busiest_room", 64'(busiest_room), 64'(bk.top_room));
			if (busiest_count !== bk.top_count)
				report_mismatch("busiest_count", 64'(busiest_count), 64'(bk.top_count));
		end
	endtask

	// channel monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rooms_cfg = 8'd1;
			clear_rooms();
			booking_q.delete();
			mismatches = 0;
			pending <= 0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (cfg_valid && cfg_ready)
				rooms_cfg = cfg_data;
			if (in_valid && in_ready)
				book_job(req_start, req_end, first_job);
			pending <= booking_q.size();
		end
	end

endmodule

// ----- verif/lowest_free_room_scheduler_top_test.sv -----
// ----------------------------------------------------------------------------
// lowest_free_room_scheduler_top_test
// Drives directed and random job streams into the scheduler over a range of
// room counts and idle patterns; the checker beside the block does the
// prediction and comparison, this module gives the verdict.
// ----------------------------------------------------------------------------
module lowest_free_room_scheduler_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_ROOMS   = 128;
	localparam int TIME_BITS   = 40;
	localparam int COUNT_BITS  = 17;
	localparam int RANDOM_JOBS = 750;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [lfrs_pkg::START_BITS-1:0] T_MAX = '1;

	logic                                clk = 1'b0;
	logic                                arst_n = 1'b0;
	logic                                cfg_valid = 1'b0;
	logic                                cfg_ready;
	logic [lfrs_pkg::CFG_BITS-1:0]       cfg_data = '0;
	logic                                in_valid = 1'b0;
	logic                                in_ready;
	logic [lfrs_pkg::START_BITS-1:0]     req_start = '0;
	logic [lfrs_pkg::START_BITS-1:0]     req_end = '0;
	logic                                first_job = 1'b0;
	logic                                out_valid;
	logic                                out_ready = 1'b0;
	logic [lfrs_pkg::ROOM_OUT_BITS-1:0]  room;
	logic [lfrs_pkg::TIME_OUT_BITS-1:0]  actual_start;
	logic [lfrs_pkg::TIME_OUT_BITS-1:0]  actual_end;
	logic [lfrs_pkg::ROOM_OUT_BITS-1:0]  busiest_room;
	logic [lfrs_pkg::COUNT_OUT_BITS-1:0] busiest_count;

	int mismatches;
	int pending;
	int send_idle_pct = 10;
	int recv_idle_pct = 63;
	int random_jobs = 0;
	int next_start = 0;
	int cycle_count = 0;

	lowest_free_room_scheduler_top #(
		.MAX_ROOMS  (MAX_ROOMS),
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_start     (req_start),
		.req_end       (req_end),
		.first_job     (first_job),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.room          (room),
		.actual_start  (actual_start),
		.actual_end    (actual_end),
		.busiest_room  (busiest_room),
		.busiest_count (busiest_count)
	);

	lowest_free_room_scheduler_checker #(
		.MAX_ROOMS  (MAX_ROOMS),
		.TIME_BITS  (TIME_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_start     (req_start),
		.req_end       (req_end),
		.first_job     (first_job),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.room          (room),
		.actual_start  (actual_start),
		.actual_end    (actual_end),
		.busiest_room  (busiest_room),
		.busiest_count (busiest_count),
		.mismatches    (mismatches),
		.pending       (pending)
	);

	// clock
	always #6 clk = ~clk;

	// result receiver with random stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// run time guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[lowest_free_room_scheduler_top] ERROR");
			$finish;
		end
	end

	// present one job transaction and hold it until accepted
	task automatic send_job(input logic [lfrs_pkg::START_BITS-1:0] s,
			input logic [lfrs_pkg::START_BITS-1:0] e, input logic clr);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_start <= s;
		req_end <= e;
		first_job <= clr;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// drain every outstanding booking
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// room count register write, only with the block drained
	task automatic write_rooms(input logic [lfrs_pkg::CFG_BITS-1:0] v);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// idle pattern by progress through the random part
	task automatic set_idle_mode();
		if (random_jobs < RANDOM_JOBS / 3) begin
			send_idle_pct = 10;
			recv_idle_pct = 63;
		end else if (random_jobs < 2 * RANDOM_JOBS / 3) begin
			send_idle_pct = 63;
			recv_idle_pct = 10;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endtask

	// one random phase: sorted job stream with some noise
	task automatic run_phase(input int rc, input int n, input bit fresh);
		int gap_max;
		int dur_max;
		int pick;
		int s;
		int e;
		int d;
		bit clr;
		write_rooms(rc[lfrs_pkg::CFG_BITS-1:0]);
		gap_max = $urandom_range(1, 40);
		dur_max = 1 << $urandom_range(1, 12);
		for (int k = 0; k < n; k++) begin
			clr = (k == 0) && fresh;
			pick = $urandom_range(0, 99);
			d = ($urandom_range(0, 99) < 3) ? $urandom_range(0, T_MAX) : $urandom_range(1, dur_max);
			if (pick < 4) begin
				// out of order start, stream position kept
				s = $urandom_range(0, T_MAX);
				e = s + d;
			end else begin
				if (pick < 7)
					clr = 1'b1;
				if (clr)
					s = $urandom_range(0, T_MAX);
				else
					s = next_start + $urandom_range(1, gap_max);
				// start past the top of the range: restart the stream
				if (s > T_MAX) begin
					clr = 1'b1;
					s = $urandom_range(0, 999);
				end
				next_start = s;
				e = s + d;
				// end at or before start
				if (pick < 11)
					e = s - $urandom_range(0, (s < 64) ? s : 64);
			end
			if (e > T_MAX)
				e = T_MAX;
			set_idle_mode();
			send_job(s[lfrs_pkg::START_BITS-1:0], e[lfrs_pkg::START_BITS-1:0], clr);
			random_jobs++;
		end
	endtask

	// stimulus and verdict
	initial begin
		int r;
		int rc;
		int n;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// single room after reset: delay, zero length, extreme times
		send_job(20'd0, 20'd10, 1'b1);
		send_job(20'd5, 20'd8, 1'b0);
		send_job(20'd20, 20'd20, 1'b0);
		send_job(T_MAX - 20'd1, T_MAX, 1'b0);
		send_job(T_MAX, 20'd1, 1'b0);

		// three rooms: all busy, earliest freeing room, then free again
		write_rooms(8'd3);
		send_job(20'd0, 20'd100, 1'b1);
		send_job(20'd1, 20'd50, 1'b0);
		send_job(20'd2, 20'd30, 1'b0);
		send_job(20'd3, 20'd10, 1'b0);
		send_job(20'd200, T_MAX, 1'b0);
		send_job(20'd6, 20'd9, 1'b0);

		// reduced room count, rooms above keep their counts
		write_rooms(8'd1);
		send_job(20'd300, 20'd301, 1'b0);
		send_job(20'd302, 20'd303, 1'b0);

		// zero room count behaves as one room
		write_rooms(8'd0);
		send_job(20'd0, T_MAX, 1'b1);
		send_job(20'd1, 20'd2, 1'b0);

		// count above the room limit saturates
		write_rooms(8'hFF);
		send_job(20'd0, 20'd5, 1'b1);
		send_job(20'd1, 20'd5, 1'b0);
		send_job(20'd2, 20'd5, 1'b0);

		// full room range
		write_rooms(8'd128);
		send_job(20'd10, 20'd20, 1'b0);

		// random phases over several room counts
		while (random_jobs < RANDOM_JOBS) begin
			r = $urandom_range(0, 99);
			if (r < 4)
				rc = 0;
			else if (r < 8)
				rc = 255;
			else if (r < 12)
				rc = MAX_ROOMS;
			else if (r < 16)
				rc = $urandom_range(9, MAX_ROOMS - 1);
			else
				rc = $urandom_range(1, 8);
			n = (rc > 8) ? $urandom_range(8, 14) : $urandom_range(15, 40);
			run_phase(rc, n, $urandom_range(0, 99) < 80);
		end

		// drain and let the block settle
		wait_idle();
		repeat (140) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("[lowest_free_room_scheduler_top] OK");
		else
			$display("[lowest_free_room_scheduler_top] ERROR");
		$finish;
	end

endmodule

// ----- lowest_free_room_scheduler_top.f -----
rtl/core/lfrs_pkg.sv
rtl/core/lfrs_room_store.sv
rtl/core/lfrs_scan.sv
rtl/core/lowest_free_room_scheduler_top.sv
verif/lowest_free_room_scheduler_checker.sv
verif/lowest_free_room_scheduler_top_test.sv
